/* rtl/pbo_pkg.sv */
// shared types, constants and series tables for precessing_body_orientation
// depends on nothing; every rtl file imports it
package pbo_pkg;

    localparam int PHASE_LAT = 4;
    localparam int SC_LAT    = 22;
    localparam int QUAT_LAT  = 2;
    localparam int PIPE_LAT  = PHASE_LAT + SC_LAT + QUAT_LAT;

    localparam int COS_STEPS = 6;
    localparam int SIN_STEPS = 5;
    localparam int HORNER_STAGES = 3 * COS_STEPS;

    localparam logic [31:0] PI_QUARTER_Q32 = 32'hC90F_DAA2;
    localparam logic [32:0] ONE32          = 33'h1_0000_0000;

    typedef enum logic [2:0] {
        REG_EPOCH_TIME      = 3'd0,
        REG_SPIN_RATE       = 3'd1,
        REG_SPIN_OFFSET     = 3'd2,
        REG_TILT_ANGLE      = 3'd3,
        REG_NODE_ANGLE      = 3'd4,
        REG_PRECESSION_RATE = 3'd5
    } pbo_reg_t;

    typedef struct packed {
        logic signed [63:0] epoch_time;
        logic [47:0]        spin_rate;
        logic [31:0]        spin_offset;
        logic [31:0]        tilt_angle;
        logic [31:0]        node_angle;
        logic signed [47:0] precession_rate;
    } pbo_cfg_t;

    function automatic logic [7:0] sin_div(input logic [2:0] idx);
        logic [7:0] k;
        case (idx)
            3'd0:    k = 8'd110;
            3'd1:    k = 8'd72;
            3'd2:    k = 8'd42;
            3'd3:    k = 8'd20;
            3'd4:    k = 8'd6;
            default: k = 8'd6;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] sin_recip(input logic [2:0] idx);
        logic [31:0] m;
        case (idx)
            3'd0:    m = 32'd39045157;
            3'd1:    m = 32'd59652323;
            3'd2:    m = 32'd102261126;
            3'd3:    m = 32'd214748364;
            3'd4:    m = 32'd715827882;
            default: m = 32'd715827882;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] cos_div(input logic [2:0] idx);
        logic [7:0] k;
        case (idx)
            3'd0:    k = 8'd132;
            3'd1:    k = 8'd90;
            3'd2:    k = 8'd56;
            3'd3:    k = 8'd30;
            3'd4:    k = 8'd12;
            3'd5:    k = 8'd2;
            default: k = 8'd2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] cos_recip(input logic [2:0] idx);
        logic [31:0] m;
        case (idx)
            3'd0:    m = 32'd32537631;
            3'd1:    m = 32'd47721858;
            3'd2:    m = 32'd76695844;
            3'd3:    m = 32'd143165576;
            3'd4:    m = 32'd357913941;
            3'd5:    m = 32'd2147483648;
            default: m = 32'd2147483648;
        endcase
        return m;
    endfunction

endpackage

/* rtl/pbo_phase.sv */
// time difference, rate products and half-angle phases, four stages
// depends on pbo_pkg
module pbo_phase import pbo_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  pbo_cfg_t           cfg,
    input  logic signed [63:0] time_days,
    output logic [32:0]        spin_phase,
    output logic [32:0]        x_phase,
    output logic [32:0]        y_phase
);

    logic [64:0] d_reg;
    logic [63:0] sp00_reg, sp10_reg, pp00_reg, pp10_reg, pp01_reg;
    logic [47:0] sp01_reg;
    logic        pbit_reg;
    logic [31:0] frac_reg;
    logic [32:0] node_reg;
    logic [32:0] sphase_reg, xphase_reg, yphase_reg;

    logic [31:0] a0, a1, b0, c0, c1;
    logic [15:0] b1;
    logic        a2, c2;

    always_comb
    begin
        a0 = d_reg[31:0];
        a1 = d_reg[63:32];
        a2 = d_reg[64];
        b0 = cfg.spin_rate[31:0];
        b1 = cfg.spin_rate[47:32];
        c0 = cfg.precession_rate[31:0];
        c1 = {{16{cfg.precession_rate[47]}}, cfg.precession_rate[47:32]};
        c2 = cfg.precession_rate[47];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg    <= {time_days[63], time_days} - {cfg.epoch_time[63], cfg.epoch_time};
            sp00_reg <= a0 * b0;
            sp01_reg <= a0 * b1;
            sp10_reg <= a1 * b0;
            pp00_reg <= a0 * c0;
            pp01_reg <= a0 * c1;
            pp10_reg <= a1 * c0;
            pbit_reg <= (a0[0] & c2) ^ (a2 & c0[0]) ^ (a1[0] & c1[0]);
            frac_reg <= sp00_reg[63:32] + sp01_reg[31:0] + sp10_reg[31:0];
            node_reg <= {1'b0, pp00_reg[63:32]} + pp01_reg[32:0] + pp10_reg[32:0]
                        + {pbit_reg, 32'b0};
            sphase_reg <= 33'd0 - ({1'b0, frac_reg} + 33'h0_8000_0000
                          + {1'b0, cfg.spin_offset});
            xphase_reg <= 33'd0 - {1'b0, cfg.tilt_angle};
            yphase_reg <= node_reg - {1'b0, cfg.node_angle};
        end
    end

    assign spin_phase = sphase_reg;
    assign x_phase    = xphase_reg;
    assign y_phase    = yphase_reg;

endmodule

/* rtl/pbo_sincos.sv */
// pipelined sine and cosine of a half-angle phase, octant fold and horner series
// depends on pbo_pkg
module pbo_sincos import pbo_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [32:0]        phase,
    output logic signed [31:0] cos_val,
    output logic signed [31:0] sin_val
);

    typedef struct packed {
        logic [31:0] t2;
        logic [31:0] theta;
        logic [2:0]  oct;
    } carry_t;

    logic [30:0] rr_reg;
    logic [2:0]  oct_a_reg, oct_b_reg;
    logic [31:0] theta_b_reg;
    carry_t      carry_reg [HORNER_STAGES + 1];

    logic [32:0] acc_c_reg [COS_STEPS];
    logic [32:0] acc_s_reg [SIN_STEPS];
    logic [31:0] sv_reg, sv_d1_reg, sv_d2_reg;
    logic signed [31:0] cos_reg, sin_reg;

    logic [62:0] theta_prod;
    logic [63:0] t2_prod;
    logic [64:0] sv_prod;

    always_comb
    begin
        theta_prod = rr_reg * PI_QUARTER_Q32 + 63'h2000_0000;
        t2_prod    = theta_b_reg * theta_b_reg;
        sv_prod    = carry_reg[3 * SIN_STEPS].theta * acc_s_reg[SIN_STEPS - 1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rr_reg      <= phase[30] ? (31'h4000_0000 - {1'b0, phase[29:0]})
                                     : {1'b0, phase[29:0]};
            oct_a_reg   <= phase[32:30];
            theta_b_reg <= theta_prod[61:30];
            oct_b_reg   <= oct_a_reg;
            carry_reg[0] <= '{t2: t2_prod[63:32], theta: theta_b_reg, oct: oct_b_reg};
            sv_reg      <= sv_prod[63:32];
            sv_d1_reg   <= sv_reg;
            sv_d2_reg   <= sv_d1_reg;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= HORNER_STAGES; k++)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    carry_reg[k] <= carry_reg[k - 1];
                end
            end
        end

        for (k = 0; k < COS_STEPS; k++)
        begin : g_cos
            logic [31:0] q_reg, qq_reg, est_reg;
            logic [32:0] acc_in;
            logic [64:0] qprod;
            logic [63:0] eprod;
            logic [39:0] ek, rem;
            logic [31:0] estc;
            always_comb
            begin
                acc_in = (k == 0) ? ONE32 : acc_c_reg[(k == 0) ? 0 : k - 1];
                qprod  = carry_reg[3 * k].t2 * acc_in;
                eprod  = q_reg * cos_recip(3'(k));
                ek     = est_reg * cos_div(3'(k));
                rem    = {8'b0, qq_reg} - ek;
                estc   = (rem >= {32'b0, cos_div(3'(k))}) ? est_reg + 32'd1 : est_reg;
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg        <= qprod[63:32];
                    qq_reg       <= q_reg;
                    est_reg      <= eprod[63:32];
                    acc_c_reg[k] <= ONE32 - {1'b0, estc};
                end
            end
        end

        for (k = 0; k < SIN_STEPS; k++)
        begin : g_sin
            logic [31:0] q_reg, qq_reg, est_reg;
            logic [32:0] acc_in;
            logic [64:0] qprod;
            logic [63:0] eprod;
            logic [39:0] ek, rem;
            logic [31:0] estc;
            always_comb
            begin
                acc_in = (k == 0) ? ONE32 : acc_s_reg[(k == 0) ? 0 : k - 1];
                qprod  = carry_reg[3 * k].t2 * acc_in;
                eprod  = q_reg * sin_recip(3'(k));
                ek     = est_reg * sin_div(3'(k));
                rem    = {8'b0, qq_reg} - ek;
                estc   = (rem >= {32'b0, sin_div(3'(k))}) ? est_reg + 32'd1 : est_reg;
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg        <= qprod[63:32];
                    qq_reg       <= q_reg;
                    est_reg      <= eprod[63:32];
                    acc_s_reg[k] <= ONE32 - {1'b0, estc};
                end
            end
        end
    endgenerate

    logic [2:0]         oct_f;
    logic [33:0]        co_sum;
    logic [32:0]        si_sum;
    logic signed [31:0] si_r, co_r, si_sw, co_sw;

    always_comb
    begin
        oct_f  = carry_reg[HORNER_STAGES].oct;
        si_sum = {1'b0, sv_d2_reg} + 33'd2;
        co_sum = {1'b0, acc_c_reg[COS_STEPS - 1]} + 34'd2;
        si_r   = {1'b0, si_sum[32:2]};
        co_r   = co_sum[33:2];
        if (oct_f[1] ^ oct_f[0])
        begin
            si_sw = co_r;
            co_sw = si_r;
        end
        else
        begin
            si_sw = si_r;
            co_sw = co_r;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= oct_f[2] ? -si_sw : si_sw;
            cos_reg <= (oct_f[2] ^ oct_f[1]) ? -co_sw : co_sw;
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

/* rtl/pbo_quat.sv */
// equator quaternion product of x and y rotations, rounded to q2.30; spin values delayed alongside
// depends on pbo_pkg
module pbo_quat import pbo_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] sc,
    input  logic signed [31:0] ss,
    input  logic signed [31:0] xc,
    input  logic signed [31:0] xs,
    input  logic signed [31:0] yc,
    input  logic signed [31:0] ys,
    output logic signed [31:0] spin_w,
    output logic signed [31:0] spin_y,
    output logic signed [31:0] equator_w,
    output logic signed [31:0] equator_x,
    output logic signed [31:0] equator_y,
    output logic signed [31:0] equator_z
);

    logic signed [63:0] pw_reg, px_reg, py_reg, pz_reg;
    logic signed [31:0] sc_reg, ss_reg;
    logic signed [31:0] sw_reg, sy_reg, ew_reg, ex_reg, ey_reg, ez_reg;

    function automatic logic signed [31:0] round30(input logic signed [63:0] p);
        logic signed [63:0] r;
        r = (p + 64'sd536870912) >>> 30;
        return r[31:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pw_reg <= xc * yc;
            px_reg <= xs * yc;
            py_reg <= xc * ys;
            pz_reg <= xs * ys;
            sc_reg <= sc;
            ss_reg <= ss;
            ew_reg <= round30(pw_reg);
            ex_reg <= round30(px_reg);
            ey_reg <= round30(py_reg);
            ez_reg <= round30(pz_reg);
            sw_reg <= sc_reg;
            sy_reg <= ss_reg;
        end
    end

    assign spin_w    = sw_reg;
    assign spin_y    = sy_reg;
    assign equator_w = ew_reg;
    assign equator_x = ex_reg;
    assign equator_y = ey_reg;
    assign equator_z = ez_reg;

endmodule

/* rtl/precessing_body_orientation.sv */
// top level of precessing_body_orientation: config registers, valid chain, output slot
// depends on pbo_pkg, pbo_phase, pbo_sincos, pbo_quat
//
// usage
//   s_axis carries one query time per item (q32.32 days, signed)
//   m_axis returns per item the spin quaternion (w, y) and the equator quaternion
//   (w, x, y, z), all signed q2.30; cfg writes one of six registers by index;
//   always ready; the user writes only while idle, the block does not enforce it
// pipeline stages and throughput
//   from the input accept edge to m_axis_tvalid: 4 phase stages
//   (the first loads at the accept edge), 22 sine and cosine stages (octant
//   fold, theta, square, six horner steps of three stages each, sign),
//   2 quaternion stages, then the output register
//   one item per cycle sustained while the output is not stalled
// reset
//   rst_n zeroes the config registers and valid flags and empties the pipeline
// stall
//   a waiting result sits in the output register; the pipeline keeps taking
//   items until a finished one reaches its last stage, then the whole
//   pipeline holds and s_axis_tready drops; nothing is lost or repeated
module precessing_body_orientation import pbo_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [63:0]   s_axis_tdata,   // time_days
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [191:0]  m_axis_tdata,   // spin_w, spin_y, equator_w, _x, _y, _z
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [63:0]   cfg_data
);

    pbo_cfg_t cfg_reg;
    logic [PIPE_LAT-1:0] vld_reg;
    logic                out_valid_reg;
    logic [191:0]        out_data_reg;
    logic                out_free, en;

    logic [32:0]        sphase, xphase, yphase;
    logic signed [31:0] sc, ss, xc, xs, yc, ys;
    logic signed [31:0] spin_w, spin_y, eq_w, eq_x, eq_y, eq_z;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign en        = !vld_reg[PIPE_LAT-1] || out_free;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (pbo_reg_t'(cfg_index))
                REG_EPOCH_TIME:      cfg_reg.epoch_time      <= cfg_data;
                REG_SPIN_RATE:       cfg_reg.spin_rate       <= cfg_data[47:0];
                REG_SPIN_OFFSET:     cfg_reg.spin_offset     <= cfg_data[31:0];
                REG_TILT_ANGLE:      cfg_reg.tilt_angle      <= cfg_data[31:0];
                REG_NODE_ANGLE:      cfg_reg.node_angle      <= cfg_data[31:0];
                REG_PRECESSION_RATE: cfg_reg.precession_rate <= cfg_data[47:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[PIPE_LAT-2:0], s_axis_tvalid};
            end
            if (out_free)
            begin
                out_valid_reg <= vld_reg[PIPE_LAT-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && vld_reg[PIPE_LAT-1])
        begin
            out_data_reg <= {eq_z, eq_y, eq_x, eq_w, spin_y, spin_w};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    pbo_phase u_phase (
        .clk        (clk),
        .en         (en),
        .cfg        (cfg_reg),
        .time_days  (s_axis_tdata),
        .spin_phase (sphase),
        .x_phase    (xphase),
        .y_phase    (yphase)
    );

    pbo_sincos u_sc_spin (.clk(clk), .en(en), .phase(sphase), .cos_val(sc), .sin_val(ss));
    pbo_sincos u_sc_x    (.clk(clk), .en(en), .phase(xphase), .cos_val(xc), .sin_val(xs));
    pbo_sincos u_sc_y    (.clk(clk), .en(en), .phase(yphase), .cos_val(yc), .sin_val(ys));

    pbo_quat u_quat (
        .clk       (clk),
        .en        (en),
        .sc        (sc),
        .ss        (ss),
        .xc        (xc),
        .xs        (xs),
        .yc        (yc),
        .ys        (ys),
        .spin_w    (spin_w),
        .spin_y    (spin_y),
        .equator_w (eq_w),
        .equator_x (eq_x),
        .equator_y (eq_y),
        .equator_z (eq_z)
    );

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted item missing from first stage");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid chain moved during stall");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !en |-> vld_reg[PIPE_LAT-1] && m_axis_tvalid && !m_axis_tready)
        else $error("pipeline held without a blocked result");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[PIPE_LAT-1] && out_free |=> m_axis_tvalid)
        else $error("finished item not moved to output");

endmodule
